// ----- design/upc_pkg.sv -----
package upc_pkg;

    // mode register codes
    localparam logic [1:0] MODE_ENCODE    = 2'd0;
    localparam logic [1:0] MODE_DECODE    = 2'd1;
    localparam logic [1:0] MODE_NORMALIZE = 2'd2;

    // characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;

    // default depth of the queue between front and back
    localparam int UPC_FIFO_DEPTH = 4;

    // one decoded byte on its way to the back end
    typedef struct packed {
        logic [7:0] data;
        logic       enc;
        logic       last;
    } upc_entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
               (c >= CH_LO_A && c <= CH_LO_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + 8'd10;
        end else begin
            v = c - CH_LO_A + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDER || c == CH_TILDE ||
               c == CH_DOT || c == CH_DASH;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return CH_ZERO + {4'd0, n};
        end
        return CH_UP_A + {4'd0, n} - 8'd10;
    endfunction

endpackage

// ----- design/url_percent_codec_unit.sv -----
// channel | ports                                  | direction | role
// s_      | s_valid s_ready s_in_byte s_in_last    | in        | raw string words
// m_      | m_valid m_ready m_out_byte m_out_last  | out       | converted string words
// cfg_    | cfg_we cfg_wdata                       | in        | mode register write
//
// The back end sends one output word per cycle unless m_ready holds it, and an input word
// produces 1 or 3 output words in encode, 0 to 3 in decode (a held escape byte produces
// none), up to 7 in normalize. Words pass the front end list, the queue and the back
// end output register in turn. The front end turns each input word into up to three
// decoded bytes, one per cycle while the queue has room, and takes the next word as
// the last of them enters the queue. Synchronous active-low reset clears mode to encode
// and drops any held escape. Either side stalls independently through the queue.
module url_percent_codec_unit #(
    parameter int FIFO_DEPTH = upc_pkg::UPC_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last
);
    import upc_pkg::*;

    upc_entry_t  f_entry, b_entry;
    logic        f_valid, f_ready, b_valid, b_ready;

    // classify and decode
    upc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_entry   (f_entry),
        .q_valid   (f_valid),
        .q_ready   (f_ready)
    );

    // decoupling queue
    upc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_entry  (f_entry),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_entry (b_entry),
        .out_valid (b_valid),
        .out_ready (b_ready)
    );

    // percent expansion and output register
    upc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_entry    (b_entry),
        .q_valid    (b_valid),
        .q_ready    (b_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule

// ----- design/upc_fifo.sv -----
module upc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  upc_pkg::upc_entry_t   in_entry,
    input  logic                  in_valid,
    output logic                  in_ready,
    output upc_pkg::upc_entry_t   out_entry,
    output logic                  out_valid,
    input  logic                  out_ready
);
    import upc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upc_entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_wr, do_rd;

    // handshake on both sides
    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_ready && out_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ----- design/upc_front.sv -----
module upc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  logic                  s_in_last,
    output upc_pkg::upc_entry_t   q_entry,
    output logic                  q_valid,
    input  logic                  q_ready
);
    import upc_pkg::*;

    logic [1:0]  mode_reg;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [7:0]  pend_digit_reg, pend_digit_next;
    logic [7:0]  list_reg [3];
    logic [7:0]  list_next [3];
    logic [1:0]  list_cnt_reg, list_cnt_next;
    logic        list_enc_reg, list_enc_next;
    logic        list_last_reg;
    logic        push, accept;

    // queue side: one decoded byte per cycle from the head of the list while q_ready is high
    assign q_valid      = (list_cnt_reg != 2'd0);
    assign push         = q_valid && q_ready;
    assign q_entry.data = list_reg[0];
    assign q_entry.enc  = list_enc_reg;
    assign q_entry.last = list_last_reg && (list_cnt_reg == 2'd1);

    // take a new word once the list drains
    assign s_ready = (list_cnt_reg == 2'd0) || (list_cnt_reg == 2'd1 && push);
    assign accept  = s_valid && s_ready;

    // classify the incoming byte into up to three decoded bytes
    always_comb begin
        logic [1:0] n;
        logic       hv;
        n               = 2'd0;
        hv              = is_hex(s_in_byte);
        pend_cnt_next   = pend_cnt_reg;
        pend_digit_next = pend_digit_reg;
        list_next[0]    = s_in_byte;
        list_next[1]    = s_in_byte;
        list_next[2]    = s_in_byte;
        list_enc_next   = (mode_reg != MODE_DECODE);
        if (mode_reg != MODE_DECODE && mode_reg != MODE_NORMALIZE) begin
            // plain encode
            n = 2'd1;
        end else begin
            case (pend_cnt_reg)
                2'd0: begin
                    if (s_in_byte == CH_PERCENT) begin
                        pend_cnt_next = 2'd1;
                    end else begin
                        n = 2'd1;
                    end
                end
                2'd1: begin
                    if (hv) begin
                        pend_cnt_next   = 2'd2;
                        pend_digit_next = s_in_byte;
                    end else if (s_in_byte == CH_PERCENT) begin
                        list_next[0]  = CH_PERCENT;
                        n             = 2'd1;
                        pend_cnt_next = 2'd1;
                    end else begin
                        list_next[0]  = CH_PERCENT;
                        n             = 2'd2;
                        pend_cnt_next = 2'd0;
                    end
                end
                default: begin
                    // two held: complete escape or broken escape
                    if (hv) begin
                        list_next[0]    = {hex_val(pend_digit_reg), hex_val(s_in_byte)};
                        n               = 2'd1;
                        pend_cnt_next   = 2'd0;
                        pend_digit_next = 8'd0;
                    end else begin
                        list_next[0]    = CH_PERCENT;
                        list_next[1]    = pend_digit_reg;
                        pend_digit_next = 8'd0;
                        if (s_in_byte == CH_PERCENT) begin
                            n             = 2'd2;
                            pend_cnt_next = 2'd1;
                        end else begin
                            n             = 2'd3;
                            pend_cnt_next = 2'd0;
                        end
                    end
                end
            endcase
            // flush held bytes at end of string
            if (s_in_last) begin
                if (pend_cnt_next != 2'd0) begin
                    list_next[n] = CH_PERCENT;
                    n            = n + 2'd1;
                end
                if (pend_cnt_next == 2'd2) begin
                    list_next[n] = pend_digit_next;
                    n            = n + 2'd1;
                end
                pend_cnt_next   = 2'd0;
                pend_digit_next = 8'd0;
            end
        end
        list_cnt_next = n;
    end

    // decode state and mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_ENCODE;
            pend_cnt_reg   <= 2'd0;
            pend_digit_reg <= 8'd0;
        end else if (cfg_we) begin
            mode_reg       <= cfg_wdata;
            pend_cnt_reg   <= 2'd0;
            pend_digit_reg <= 8'd0;
        end else if (accept) begin
            pend_cnt_reg   <= pend_cnt_next;
            pend_digit_reg <= pend_digit_next;
        end
    end

    // pending list count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_cnt_reg <= 2'd0;
        end else if (accept) begin
            list_cnt_reg <= list_cnt_next;
        end else if (push) begin
            list_cnt_reg <= list_cnt_reg - 2'd1;
        end
    end

    // pending list payload, shifts toward the head on each push
    always_ff @(posedge aclk) begin
        if (accept) begin
            list_reg[0]   <= list_next[0];
            list_reg[1]   <= list_next[1];
            list_reg[2]   <= list_next[2];
            list_enc_reg  <= list_enc_next;
            list_last_reg <= s_in_last;
        end else if (push) begin
            list_reg[0] <= list_reg[1];
            list_reg[1] <= list_reg[2];
        end
    end

endmodule

// ----- design/upc_back.sv -----
module upc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  upc_pkg::upc_entry_t   q_entry,
    input  logic                  q_valid,
    output logic                  q_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_out_last
);
    import upc_pkg::*;

    typedef enum logic [1:0] {
        PH_PCT,
        PH_HI,
        PH_LO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;
    logic        load, take, expand, final_word;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

    // output register frees when empty or taken
    assign load       = !m_valid_reg || m_ready;
    assign take       = load && q_valid;
    assign expand     = q_entry.enc && !is_unreserved(q_entry.data);
    assign final_word = !expand || (phase_reg == PH_LO);
    assign q_ready    = take && final_word;

    // pick the output word for this phase
    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        phase_next   = phase_reg;
        if (load) begin
            m_valid_next = q_valid;
        end
        if (take) begin
            m_last_next = q_entry.last && final_word;
            if (!expand) begin
                m_byte_next = q_entry.data;
            end else begin
                case (phase_reg)
                    PH_PCT:  m_byte_next = CH_PERCENT;
                    PH_HI:   m_byte_next = hex_char(q_entry.data[7:4]);
                    default: m_byte_next = hex_char(q_entry.data[3:0]);
                endcase
            end
            if (final_word) begin
                phase_next = PH_PCT;
            end else if (phase_reg == PH_PCT) begin
                phase_next = PH_HI;
            end else begin
                phase_next = PH_LO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PCT;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            m_byte_reg  <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
            m_byte_reg  <= m_byte_next;
        end
    end

endmodule
